// ----- rtl/rrq_pkg.sv -----
// Shared types and codes for the round-robin thread run queue.
// Depends on nothing; used by rrq_queue and round_robin_thread_run_queue.
`timescale 1ns / 1ps

package rrq_pkg;

   typedef enum logic [2:0] {
      CMD_ENQUEUE   = 3'd0,
      CMD_REMOVE    = 3'd1,
      CMD_BLOCK     = 3'd2,
      CMD_UNBLOCK   = 3'd3,
      CMD_SET_STATE = 3'd4,
      CMD_GET_STATE = 3'd5,
      CMD_RUN       = 3'd6,
      CMD_QUERY     = 3'd7
   } command_type;

   typedef enum logic [1:0] {
      ST_RUNNABLE   = 2'd0,
      ST_RUNNING    = 2'd1,
      ST_BLOCKED    = 2'd2,
      ST_TERMINATED = 2'd3
   } thread_state_type;

   typedef enum logic [1:0] {
      Q_NOP    = 2'd0,
      Q_APPEND = 2'd1,
      Q_UNLINK = 2'd2,
      Q_ROTATE = 2'd3
   } q_op_type;

endpackage

// ----- rtl/round_robin_thread_run_queue.sv -----
// Top level of the round-robin thread run queue: command register, thread
// state table, current thread and result register. Depends on rrq_pkg, rrq_queue.
`timescale 1ns / 1ps

// One command is taken per clock: busy is never raised, so start may be held
// high every cycle. The command is registered, acted on against the queue and
// thread state tables in the following cycle, and its result word shows on
// the rsp_ ports in the cycle after that, flagged by rsp_strobe for a single cycle.
// Each command's result already reflects every earlier command.
// The receiver cannot stall and must take each word as it comes. The idle
// thread register may be written at any time the block holds no command.

module round_robin_thread_run_queue #(
   parameter int THREADS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_command,
   input  logic [$clog2(THREADS+1)-1:0]  req_thread_id,
   input  logic [1:0]                    req_new_thread_state,
   input  logic                          csr_write_enable,
   input  logic [$clog2(THREADS+1)-1:0]  csr_write_data,
   output logic                          rsp_strobe,
   output logic                          rsp_status,
   output logic [$clog2(THREADS+1)-1:0]  rsp_chosen_thread,
   output logic [$clog2(THREADS+1)-1:0]  rsp_running_thread,
   output logic [$clog2(THREADS+1)-1:0]  rsp_previous_thread,
   output logic                          rsp_switched,
   output logic [1:0]                    rsp_thread_state_out,
   output logic [$clog2(THREADS+1)-1:0]  rsp_queue_length
);

   localparam int IdW  = $clog2(THREADS + 1);
   localparam int IdxW = $clog2(THREADS);
   localparam logic [IdW-1:0] NoneId = IdW'(THREADS);

   // command register
   logic                      vld_ff;
   rrq_pkg::command_type      cmd_ff;
   logic [IdW-1:0]            tid_ff;
   rrq_pkg::thread_state_type ns_ff;
   logic [IdW-1:0]            idle_ff;

   // thread state and current thread
   rrq_pkg::thread_state_type st_ff [THREADS];
   rrq_pkg::thread_state_type st_in [THREADS];
   logic [IdW-1:0]            cur_ff, cur_in;

   // result register
   logic                      strobe_ff;
   logic                      status_ff, status_in;
   logic [IdW-1:0]            chosen_ff, chosen_in;
   logic [IdW-1:0]            prev_ff, prev_in;
   logic                      sw_ff, sw_in;
   rrq_pkg::thread_state_type sto_ff, sto_in;
   logic [IdW-1:0]            qlen_ff;

   rrq_pkg::q_op_type         op_kind;
   logic [IdW-1:0]            op_id;
   logic [IdW-1:0]            head, head_next, count_next;
   logic                      tvalid;
   logic [IdW-1:0]            pick_now, pick_next;
   logic [IdxW-1:0]           tidx, cidx, pidx;

   rrq_queue #(
      .THREADS (THREADS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .op_kind    (op_kind),
      .op_id      (op_id),
      .head_out   (head),
      .head_next  (head_next),
      .count_next (count_next)
   );

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         idle_ff <= NoneId;
      end else begin
         vld_ff <= start;
         if (csr_write_enable) begin
            idle_ff <= (csr_write_data < NoneId) ? csr_write_data : NoneId;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cmd_ff <= rrq_pkg::command_type'(req_command);
         tid_ff <= (req_thread_id < NoneId) ? req_thread_id : NoneId;
         ns_ff  <= rrq_pkg::thread_state_type'(req_new_thread_state);
      end
   end

   assign tvalid    = tid_ff != NoneId;
   assign tidx      = tid_ff[IdxW-1:0];
   assign cidx      = cur_ff[IdxW-1:0];
   assign pick_now  = (head != NoneId) ? head : idle_ff;
   assign pidx      = pick_now[IdxW-1:0];
   assign pick_next = (head_next != NoneId) ? head_next : idle_ff;

   always_comb begin
      st_in     = st_ff;
      cur_in    = cur_ff;
      op_kind   = rrq_pkg::Q_NOP;
      op_id     = tid_ff;
      prev_in   = NoneId;
      sw_in     = 1'b0;
      chosen_in = pick_next;
      status_in = (cmd_ff inside {[rrq_pkg::CMD_ENQUEUE:rrq_pkg::CMD_GET_STATE]})
                  && !tvalid;
      if (vld_ff) begin
         if (cmd_ff == rrq_pkg::CMD_RUN) begin
            chosen_in = pick_now;
            if (pick_now != NoneId && pick_now != cur_ff) begin
               if (cur_ff != NoneId && st_ff[cidx] == rrq_pkg::ST_RUNNING) begin
                  st_in[cidx] = rrq_pkg::ST_RUNNABLE;
               end
               st_in[pidx] = rrq_pkg::ST_RUNNING;
               // a pick from a non-empty queue is its head
               if (head != NoneId) begin
                  op_kind = rrq_pkg::Q_ROTATE;
               end
               prev_in = cur_ff;
               cur_in  = pick_now;
               sw_in   = 1'b1;
            end
         end else if (tvalid) begin
            case (cmd_ff)
               rrq_pkg::CMD_ENQUEUE: op_kind = rrq_pkg::Q_APPEND;
               rrq_pkg::CMD_REMOVE:  op_kind = rrq_pkg::Q_UNLINK;
               rrq_pkg::CMD_BLOCK: begin
                  st_in[tidx] = rrq_pkg::ST_BLOCKED;
                  op_kind     = rrq_pkg::Q_UNLINK;
               end
               rrq_pkg::CMD_UNBLOCK: begin
                  st_in[tidx] = rrq_pkg::ST_RUNNABLE;
                  op_kind     = rrq_pkg::Q_APPEND;
               end
               rrq_pkg::CMD_SET_STATE: st_in[tidx] = ns_ff;
               default: begin
               end
            endcase
         end
      end
      sto_in = tvalid ? st_in[tidx] : rrq_pkg::ST_TERMINATED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < THREADS; i++) begin
            st_ff[i] <= rrq_pkg::ST_TERMINATED;
         end
         cur_ff    <= NoneId;
         strobe_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         cur_ff    <= cur_in;
         strobe_ff <= vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (vld_ff) begin
         status_ff <= status_in;
         chosen_ff <= chosen_in;
         prev_ff   <= prev_in;
         sw_ff     <= sw_in;
         sto_ff    <= sto_in;
         qlen_ff   <= count_next;
      end
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_status           = status_ff;
   assign rsp_chosen_thread    = chosen_ff;
   assign rsp_running_thread   = cur_ff;
   assign rsp_previous_thread  = prev_ff;
   assign rsp_switched         = sw_ff;
   assign rsp_thread_state_out = sto_ff;
   assign rsp_queue_length     = qlen_ff;

   a_switch_running: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && sw_ff) |-> (cur_ff != NoneId && st_ff[cidx] == rrq_pkg::ST_RUNNING))
      else $error("switched-to thread is not marked running");

   a_switch_differs: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && sw_ff) |-> (prev_ff != cur_ff && chosen_ff == cur_ff))
      else $error("switch result inconsistent with current thread");

   a_cur_stable: assert property (@(posedge clock) disable iff (reset)
      !vld_ff |=> $stable(cur_ff))
      else $error("current thread changed without a command");

endmodule

// ----- rtl/rrq_queue.sv -----
// Doubly linked FIFO of thread numbers held in register tables.
// One append, unlink or head rotation per cycle. Depends on rrq_pkg.
`timescale 1ns / 1ps

module rrq_queue #(
   parameter int THREADS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rrq_pkg::q_op_type             op_kind,
   input  logic [$clog2(THREADS+1)-1:0]  op_id,
   output logic [$clog2(THREADS+1)-1:0]  head_out,
   output logic [$clog2(THREADS+1)-1:0]  head_next,
   output logic [$clog2(THREADS+1)-1:0]  count_next
);

   localparam int IdW  = $clog2(THREADS + 1);
   localparam int IdxW = $clog2(THREADS);
   localparam logic [IdW-1:0] NoneId = IdW'(THREADS);

   logic [IdW-1:0] next_ff [THREADS];
   logic [IdW-1:0] next_in [THREADS];
   logic [IdW-1:0] prev_ff [THREADS];
   logic [IdW-1:0] prev_in [THREADS];
   logic [THREADS-1:0] inq_ff, inq_in;
   logic [IdW-1:0] head_ff, head_in, tail_ff, tail_in, count_ff, count_in;

   logic [IdxW-1:0] idx, hidx;
   logic [IdW-1:0]  p_id, n_id, hn_id;

   assign idx   = op_id[IdxW-1:0];
   assign hidx  = head_ff[IdxW-1:0];
   assign p_id  = prev_ff[idx];
   assign n_id  = next_ff[idx];
   assign hn_id = next_ff[hidx];

   always_comb begin
      next_in  = next_ff;
      prev_in  = prev_ff;
      inq_in   = inq_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      case (op_kind)
         rrq_pkg::Q_APPEND: begin
            if (!inq_ff[idx]) begin
               next_in[idx] = NoneId;
               prev_in[idx] = tail_ff;
               if (tail_ff != NoneId) begin
                  next_in[tail_ff[IdxW-1:0]] = op_id;
               end else begin
                  head_in = op_id;
               end
               tail_in     = op_id;
               inq_in[idx] = 1'b1;
               count_in    = count_ff + IdW'(1);
            end
         end
         rrq_pkg::Q_UNLINK: begin
            if (inq_ff[idx]) begin
               if (p_id != NoneId) begin
                  next_in[p_id[IdxW-1:0]] = n_id;
               end else begin
                  head_in = n_id;
               end
               if (n_id != NoneId) begin
                  prev_in[n_id[IdxW-1:0]] = p_id;
               end else begin
                  tail_in = p_id;
               end
               next_in[idx] = NoneId;
               prev_in[idx] = NoneId;
               inq_in[idx]  = 1'b0;
               count_in     = count_ff - IdW'(1);
            end
         end
         rrq_pkg::Q_ROTATE: begin
            // head moves to the tail; nothing to do with a single entry
            if (head_ff != tail_ff) begin
               head_in                    = hn_id;
               prev_in[hn_id[IdxW-1:0]]   = NoneId;
               next_in[tail_ff[IdxW-1:0]] = head_ff;
               prev_in[hidx]              = tail_ff;
               next_in[hidx]              = NoneId;
               tail_in                    = head_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inq_ff   <= '0;
         head_ff  <= NoneId;
         tail_ff  <= NoneId;
         count_ff <= '0;
      end else begin
         inq_ff   <= inq_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // links of threads out of the queue are never read
   always_ff @(posedge clock) begin
      next_ff <= next_in;
      prev_ff <= prev_in;
   end

   assign head_out   = head_ff;
   assign head_next  = head_in;
   assign count_next = count_in;

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) == (head_ff == NoneId))
      else $error("queue count and head disagree on empty");

   a_empty_tail: assert property (@(posedge clock) disable iff (reset)
      (head_ff == NoneId) == (tail_ff == NoneId))
      else $error("queue head and tail disagree on empty");

   a_count_ones: assert property (@(posedge clock) disable iff (reset)
      $countones(inq_ff) == int'(count_ff))
      else $error("queue count does not match membership bits");

endmodule
